FILE: rtl/core/tss_pkg.sv
// Package for the timer slot scheduler: types, command and status bundles, codes.
// No dependencies; used by every module in rtl/core except tss_ram.
`default_nettype none
package tss_pkg;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_STOP   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [2:0] KIND_CREATED = 3'd0;
    localparam logic [2:0] KIND_STOPPED = 3'd1;
    localparam logic [2:0] KIND_EXPIRED = 3'd2;
    localparam logic [2:0] KIND_FULL    = 3'd3;
    localparam logic [2:0] KIND_BAD_ID  = 3'd4;

    // expiries reported per tick at most
    localparam int MAX_OUT   = 16;
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_CREATE,
        ST_RESP,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_JUDGE
    } state_t;

    typedef struct packed {
        logic capture;        // latch input transaction
        logic pop;            // read top of free stack
        logic pop_load;       // take popped slot
        logic take_new;       // take never-used slot
        logic create_commit;  // schedule new slot, emit created
        logic respond;        // emit stop / full / bad id
        logic tick;           // advance time, restart scan
        logic scan_step;      // read next slot entry
        logic free_dead;      // free due dead slot, restart scan
        logic expire;         // handle due live slot, restart scan
        logic flush;          // emit pending expiry as last
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       stack_nonempty;
        logic       hw_avail;
        logic       scan_last;
        logic       best_due;
        logic       best_dead;
        logic       pend_valid;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tss_ctrl.sv
// Controller state machine of the timer slot scheduler.
// Depends on tss_pkg; drives tss_datapath through cmd_t, reads status_t.
`default_nettype none
module tss_ctrl #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire tss_pkg::status_t sts,
    output tss_pkg::cmd_t         cmd
);

    localparam int LIMIT = NUM_SLOTS + tss_pkg::MAX_OUT + 1;
    localparam int IW    = $clog2(LIMIT + 1);
    localparam int NW    = tss_pkg::OUT_CNT_W;

    tss_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   iter_reg, iter_next;
    logic [NW-1:0]   n_reg, n_next;
    logic            go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tss_pkg::ST_IDLE;
            iter_reg  <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            n_reg     <= n_next;
        end
    end

    assign go = sts.best_due && (iter_reg < IW'(LIMIT)) && (n_reg < NW'(tss_pkg::MAX_OUT));

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        n_next     = n_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tss_pkg::ST_DECODE;
                end
            end
            tss_pkg::ST_DECODE:
            begin
                case (sts.mode)
                    tss_pkg::MODE_CREATE:
                    begin
                        if (sts.stack_nonempty)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = tss_pkg::ST_POP_WAIT;
                        end
                        else if (sts.hw_avail)
                        begin
                            cmd.take_new = 1'b1;
                            state_next   = tss_pkg::ST_CREATE;
                        end
                        else
                        begin
                            state_next = tss_pkg::ST_RESP;
                        end
                    end
                    tss_pkg::MODE_STOP:
                    begin
                        state_next = tss_pkg::ST_RESP;
                    end
                    tss_pkg::MODE_TICK:
                    begin
                        cmd.tick   = 1'b1;
                        iter_next  = '0;
                        n_next     = '0;
                        state_next = tss_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        state_next = tss_pkg::ST_IDLE;
                    end
                endcase
            end
            tss_pkg::ST_POP_WAIT:
            begin
                cmd.pop_load = 1'b1;
                state_next   = tss_pkg::ST_CREATE;
            end
            tss_pkg::ST_CREATE:
            begin
                if (sts.out_free)
                begin
                    cmd.create_commit = 1'b1;
                    state_next        = tss_pkg::ST_IDLE;
                end
            end
            tss_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = tss_pkg::ST_IDLE;
                end
            end
            tss_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = tss_pkg::ST_SCAN_WAIT;
                end
            end
            tss_pkg::ST_SCAN_WAIT:
            begin
                state_next = tss_pkg::ST_JUDGE;
            end
            tss_pkg::ST_JUDGE:
            begin
                if (go && sts.best_dead)
                begin
                    cmd.free_dead = 1'b1;
                    iter_next     = iter_reg + 1'b1;
                    state_next    = tss_pkg::ST_SCAN;
                end
                else if (go)
                begin
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.expire = 1'b1;
                        iter_next  = iter_reg + 1'b1;
                        n_next     = n_reg + 1'b1;
                        state_next = tss_pkg::ST_SCAN;
                    end
                end
                else if (sts.pend_valid)
                begin
                    if (sts.out_free)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = tss_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = tss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/tss_datapath.sv
// Datapath of the timer slot scheduler: time, slot flags, slot and free-stack
// RAMs, deadline scan, pending expiry and output register. Uses tss_pkg, tss_ram.
`default_nettype none
module tss_datapath #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tss_pkg::cmd_t cmd,
    output tss_pkg::status_t   sts,
    input  wire logic [1:0]    mode,
    input  wire logic [31:0]   delay,
    input  wire logic [31:0]   period,
    input  wire logic [3:0]    timer_id,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         kind,
    output logic [3:0]         slot,
    output logic [4:0]         active_count,
    output logic               last
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int TB = TIME_BITS;
    localparam int RW = TB + 64;
    localparam logic [TB-1:0] THALF = {1'b1, {(TB-1){1'b0}}};

    // captured transaction
    logic [1:0]  mode_reg;
    logic [31:0] delay_reg, period_reg;
    logic [3:0]  id_reg;

    // control state
    logic [TB-1:0]        now_reg;
    logic [31:0]          seq_reg;
    logic [CW-1:0]        hw_reg, depth_reg, cnt_reg;
    logic [NUM_SLOTS-1:0] sched_reg, dead_reg, inuse_reg;
    logic [SW-1:0]        scan_idx_reg, p_idx_reg;
    logic                 p_vld_reg, best_valid_reg, pend_valid_reg, out_valid_reg;

    // payload
    logic [SW-1:0] slot_reg, best_idx_reg;
    logic [TB-1:0] best_rank_reg, best_dl_reg;
    logic [31:0]   best_per_reg, best_stamp_reg;
    logic [SW-1:0] pend_slot_reg;
    logic [CW-1:0] pend_cnt_reg;
    logic [2:0]    out_kind_reg;
    logic [3:0]    out_slot_reg;
    logic [4:0]    out_cnt_reg;
    logic          out_last_reg;

    // RAM ports
    logic          sr_wr_en;
    logic [SW-1:0] sr_wr_addr;
    logic [RW-1:0] sr_wr_data, sr_rd_data;
    logic          fs_wr_en;
    logic [SW-1:0] fs_rd_data;
    logic [CW-1:0] depth_m1;

    // misc combinational
    logic [SW+3:0] id_ext;
    logic [SW-1:0] id_idx;
    logic          id_ok, out_free, free_en, oneshot, take;
    logic [TB-1:0] rd_dl, rd_rank;
    logic [31:0]   rd_per, rd_stamp, stamp_diff;
    logic [SW+3:0] slot_ext, pend_ext;
    logic [CW+4:0] cnt_ext, cnt_up_ext, cnt_dn_ext, pend_cnt_ext;
    logic [CW-1:0] cnt_up, cnt_dn;

    assign out_free = !out_valid_reg || !out_stall;
    assign id_ext   = {{SW{1'b0}}, id_reg};
    assign id_idx   = id_ext[SW-1:0];
    assign id_ok    = (id_ext < (SW+4)'(NUM_SLOTS)) && inuse_reg[id_idx];
    assign oneshot  = (best_per_reg == 32'd0);
    assign free_en  = cmd.free_dead || (cmd.expire && oneshot);
    assign depth_m1 = depth_reg - 1'b1;
    assign cnt_up   = cnt_reg + 1'b1;
    assign cnt_dn   = cnt_reg - 1'b1;

    assign slot_ext     = {4'd0, slot_reg};
    assign pend_ext     = {4'd0, pend_slot_reg};
    assign cnt_ext      = {5'd0, cnt_reg};
    assign cnt_up_ext   = {5'd0, cnt_up};
    assign cnt_dn_ext   = {5'd0, cnt_dn};
    assign pend_cnt_ext = {5'd0, pend_cnt_reg};

    // slot entry: deadline, period, order stamp
    assign rd_dl      = sr_rd_data[RW-1:64];
    assign rd_per     = sr_rd_data[63:32];
    assign rd_stamp   = sr_rd_data[31:0];
    assign rd_rank    = (rd_dl - now_reg) ^ THALF;
    assign stamp_diff = rd_stamp - best_stamp_reg;
    assign take = p_vld_reg && sched_reg[p_idx_reg] &&
                  (!best_valid_reg || (rd_rank < best_rank_reg) ||
                   ((rd_rank == best_rank_reg) && stamp_diff[31]));

    always_comb
    begin
        sr_wr_en   = 1'b0;
        sr_wr_addr = best_idx_reg;
        sr_wr_data = {best_dl_reg + TB'(best_per_reg), best_per_reg, seq_reg};
        if (cmd.create_commit)
        begin
            sr_wr_en   = 1'b1;
            sr_wr_addr = slot_reg;
            sr_wr_data = {now_reg + TB'(delay_reg), period_reg, seq_reg};
        end
        else if (cmd.expire && !oneshot)
        begin
            sr_wr_en = 1'b1;
        end
    end

    assign fs_wr_en = free_en && (depth_reg < CW'(NUM_SLOTS));

    tss_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .clk     (clk),
        .wr_en   (sr_wr_en),
        .wr_addr (sr_wr_addr),
        .wr_data (sr_wr_data),
        .rd_en   (cmd.scan_step),
        .rd_addr (scan_idx_reg),
        .rd_data (sr_rd_data)
    );

    tss_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_stack_ram (
        .clk     (clk),
        .wr_en   (fs_wr_en),
        .wr_addr (depth_reg[SW-1:0]),
        .wr_data (best_idx_reg),
        .rd_en   (cmd.pop),
        .rd_addr (depth_m1[SW-1:0]),
        .rd_data (fs_rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            seq_reg        <= '0;
            hw_reg         <= '0;
            depth_reg      <= '0;
            cnt_reg        <= '0;
            sched_reg      <= '0;
            dead_reg       <= '0;
            inuse_reg      <= '0;
            scan_idx_reg   <= '0;
            p_vld_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tick)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.take_new)
            begin
                hw_reg <= hw_reg + 1'b1;
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_m1;
            end
            else if (fs_wr_en)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            if (cmd.create_commit)
            begin
                seq_reg             <= seq_reg + 1'b1;
                cnt_reg             <= cnt_up;
                sched_reg[slot_reg] <= 1'b1;
                dead_reg[slot_reg]  <= 1'b0;
                inuse_reg[slot_reg] <= 1'b1;
            end
            if (cmd.respond && (mode_reg == tss_pkg::MODE_STOP) && id_ok)
            begin
                dead_reg[id_idx] <= 1'b1;
            end
            if (cmd.expire && !oneshot)
            begin
                seq_reg <= seq_reg + 1'b1;
            end
            if (free_en)
            begin
                cnt_reg                 <= cnt_dn;
                sched_reg[best_idx_reg] <= 1'b0;
                dead_reg[best_idx_reg]  <= 1'b0;
                inuse_reg[best_idx_reg] <= 1'b0;
            end
            // scan sequencing
            if (cmd.tick || cmd.free_dead || cmd.expire)
            begin
                scan_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
                p_vld_reg      <= 1'b0;
            end
            else
            begin
                p_vld_reg <= cmd.scan_step;
                if (cmd.scan_step)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            // pending expiry
            if (cmd.tick || cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.expire)
            begin
                pend_valid_reg <= 1'b1;
            end
            // output register
            if (cmd.create_commit || cmd.respond || cmd.flush || (cmd.expire && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            delay_reg  <= delay;
            period_reg <= period;
            id_reg     <= timer_id;
        end
        if (cmd.take_new)
        begin
            slot_reg <= hw_reg[SW-1:0];
        end
        if (cmd.pop_load)
        begin
            slot_reg <= fs_rd_data;
        end
        p_idx_reg <= scan_idx_reg;
        if (take && !(cmd.tick || cmd.free_dead || cmd.expire))
        begin
            best_idx_reg   <= p_idx_reg;
            best_rank_reg  <= rd_rank;
            best_dl_reg    <= rd_dl;
            best_per_reg   <= rd_per;
            best_stamp_reg <= rd_stamp;
        end
        if (cmd.expire)
        begin
            pend_slot_reg <= best_idx_reg;
            pend_cnt_reg  <= oneshot ? cnt_dn : cnt_reg;
        end
        if (cmd.create_commit)
        begin
            out_kind_reg <= tss_pkg::KIND_CREATED;
            out_slot_reg <= slot_ext[3:0];
            out_cnt_reg  <= cnt_up_ext[4:0];
            out_last_reg <= 1'b1;
        end
        else if (cmd.respond)
        begin
            out_cnt_reg  <= cnt_ext[4:0];
            out_last_reg <= 1'b1;
            if (mode_reg == tss_pkg::MODE_CREATE)
            begin
                out_kind_reg <= tss_pkg::KIND_FULL;
                out_slot_reg <= 4'd0;
            end
            else
            begin
                out_kind_reg <= id_ok ? tss_pkg::KIND_STOPPED : tss_pkg::KIND_BAD_ID;
                out_slot_reg <= id_reg;
            end
        end
        else if (cmd.flush || (cmd.expire && pend_valid_reg))
        begin
            out_kind_reg <= tss_pkg::KIND_EXPIRED;
            out_slot_reg <= pend_ext[3:0];
            out_cnt_reg  <= pend_cnt_ext[4:0];
            out_last_reg <= cmd.flush;
        end
    end

    always_comb
    begin
        sts                = '0;
        sts.mode           = mode_reg;
        sts.stack_nonempty = (depth_reg != '0);
        sts.hw_avail       = (hw_reg < CW'(NUM_SLOTS));
        sts.scan_last      = (scan_idx_reg == SW'(NUM_SLOTS - 1));
        sts.best_due       = best_valid_reg && (best_rank_reg <= THALF);
        sts.best_dead      = dead_reg[best_idx_reg];
        sts.pend_valid     = pend_valid_reg;
        sts.out_free       = out_free;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign slot         = out_slot_reg;
    assign active_count = out_cnt_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire

FILE: rtl/core/timer_slot_scheduler_top.sv
// Top level of the timer slot scheduler: pool of one-shot / periodic timers.
// Depends on tss_pkg, tss_ctrl, tss_datapath (and tss_ram below it).
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | mode, delay, period, timer_id
//   out     | out_valid/ out_stall | kind, slot, active_count, last
//
// A create passes ST_DECODE, ST_POP_WAIT (only for a slot popped from the free
// stack) and ST_CREATE; a stop passes ST_DECODE and ST_RESP; a tick runs one
// scan pass per due slot handled plus a final scan, and only that final scan
// when nothing is due. Each scan pass reads one slot entry a cycle from the
// single read port of the slot RAM, then waits in ST_SCAN_WAIT for the read
// data and decides in ST_JUDGE.
// Reset: rst_n is asynchronous; all flags, counters and time clear at once, no
// clearing pass. An output stall holds the output register and holds the
// sequencer only when a new result is due; the block takes a new transaction
// while the last result of the previous one waits.
`default_nettype none
module timer_slot_scheduler_top #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] delay,
    input  wire logic [31:0] period,
    input  wire logic [3:0]  timer_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [3:0]       slot,
    output logic [4:0]       active_count,
    output logic             last
);

    tss_pkg::cmd_t    cmd;
    tss_pkg::status_t sts;

    // sequencer: decode, scan loop, expiry/flush decisions
    tss_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // state, memories, min-deadline search, result register
    tss_datapath #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .delay        (delay),
        .period       (period),
        .timer_id     (timer_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .slot         (slot),
        .active_count (active_count),
        .last         (last)
    );

endmodule
`default_nettype wire

FILE: rtl/core/tss_checker.sv
// Port-level checks for the timer slot scheduler, bound to the top level.
// Depends on tss_pkg and timer_slot_scheduler_top.
`default_nettype none
module tss_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] kind,
    input wire logic [3:0] slot,
    input wire logic       last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot) && $stable(last))
        else $error("output changed under stall");

    // only expiries can be non-final
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != tss_pkg::KIND_EXPIRED) |-> last)
        else $error("non-expiry result without last");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == tss_pkg::KIND_FULL) |-> (slot == 4'd0))
        else $error("pool-full result with nonzero slot");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind <= tss_pkg::KIND_BAD_ID))
        else $error("undefined result kind");

endmodule

bind timer_slot_scheduler_top tss_checker u_tss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .slot      (slot),
    .last      (last)
);
`default_nettype wire

FILE: bench/timer_slot_scheduler_top_tb.sv
// Self-checking bench for timer_slot_scheduler_top: directed and random create/stop/tick traffic.
// It keeps its own slot-pool predictor and checks every output transaction in order.
// Depends on tss_pkg and the timer_slot_scheduler_top RTL.
`timescale 1ns / 100ps
module timer_slot_scheduler_top_tb;

    localparam int SLOTS  = 16;
    localparam int TW     = 48;
    localparam logic [TW-1:0] HALF = {1'b1, {(TW-1){1'b0}}};
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_START = 600;   // cycle at which the long output hold-off begins
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] delay;
        logic [31:0] period;
        logic [3:0]  timer_id;
    } timer_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic [4:0] active_count;
        logic       last;
    } timer_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = '0;
    logic [31:0] delay = '0;
    logic [31:0] period = '0;
    logic [3:0] timer_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] kind;
    logic [3:0] slot;
    logic [4:0] active_count;
    logic last;

    timer_slot_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .delay(delay), .period(period), .timer_id(timer_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .slot(slot), .active_count(active_count), .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- predictor state: a mirror of the slot pool ----------------
    logic [TW-1:0] now_us;
    logic [TW-1:0] deadline_q [SLOTS];
    logic [31:0]   period_q   [SLOTS];
    logic [31:0]   stamp_q    [SLOTS];
    logic          sched_q    [SLOTS];
    logic          dead_q     [SLOTS];
    logic          used_q     [SLOTS];
    logic [3:0]    free_lifo  [SLOTS];
    int            free_depth;
    int            next_fresh;
    logic [31:0]   seq_num;

    timer_cmd_t   pending_cmds [$];
    timer_event_t expected_events [$];
    int           mismatches = 0;
    int           n_items = 0;
    int           accepted = 0;

    function automatic logic [4:0] scheduled_count();
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            n += sched_q[i];
        return n;
    endfunction

    // deadline position relative to now; due when <= HALF
    function automatic logic [TW-1:0] rank(int s);
        return deadline_q[s] - now_us + HALF;
    endfunction

    function automatic int earliest_slot();
        int best;
        logic [31:0] dstamp;
        best = SLOTS;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!sched_q[i])
                continue;
            if (best == SLOTS)
            begin
                best = i;
                continue;
            end
            dstamp = stamp_q[i] - stamp_q[best];
            if (rank(i) < rank(best) || (rank(i) == rank(best) && dstamp[31]))
                best = i;
        end
        return best;
    endfunction

    task automatic arm_slot(int s, logic [TW-1:0] when);
        deadline_q[s] = when;
        stamp_q[s] = seq_num;
        seq_num++;
        sched_q[s] = 1'b1;
    endtask

    task automatic release_slot(int s);
        sched_q[s] = 1'b0;
        dead_q[s] = 1'b0;
        used_q[s] = 1'b0;
        if (free_depth < SLOTS)
        begin
            free_lifo[free_depth] = s[3:0];
            free_depth++;
        end
    endtask

    task automatic expect_event(logic [2:0] k, logic [3:0] s, logic fin);
        timer_event_t e;
        e.kind = k;
        e.slot = s;
        e.active_count = scheduled_count();
        e.last = fin;
        expected_events = {expected_events, e};
    endtask

    task automatic queue_cmd(timer_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // Apply one accepted transaction to the mirror and queue its expected events.
    task automatic predict_timer_events(timer_cmd_t c);
        int s;
        int n;
        n = 0;
        case (c.mode)
            tss_pkg::MODE_CREATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    s = free_lifo[free_depth];
                end
                else if (next_fresh < SLOTS)
                begin
                    s = next_fresh;
                    next_fresh++;
                end
                else
                begin
                    expect_event(tss_pkg::KIND_FULL, 4'd0, 1'b1);
                    return;
                end
                used_q[s] = 1'b1;
                dead_q[s] = 1'b0;
                period_q[s] = c.period;
                arm_slot(s, now_us + TW'(c.delay));
                expect_event(tss_pkg::KIND_CREATED, s[3:0], 1'b1);
            end
            tss_pkg::MODE_STOP:
            begin
                if (!used_q[c.timer_id])
                    expect_event(tss_pkg::KIND_BAD_ID, c.timer_id, 1'b1);
                else
                begin
                    dead_q[c.timer_id] = 1'b1;
                    expect_event(tss_pkg::KIND_STOPPED, c.timer_id, 1'b1);
                end
            end
            tss_pkg::MODE_TICK:
            begin
                now_us++;
                for (int it = 0; it < SLOTS + tss_pkg::MAX_OUT + 1 && n < tss_pkg::MAX_OUT;
                     it++)
                begin
                    s = earliest_slot();
                    if (s >= SLOTS || rank(s) > HALF)
                        break;
                    if (dead_q[s])
                    begin
                        release_slot(s);     // stopped timer leaves silently
                        continue;
                    end
                    if (period_q[s] == 0)
                        release_slot(s);
                    else
                        arm_slot(s, deadline_q[s] + TW'(period_q[s]));
                    expect_event(tss_pkg::KIND_EXPIRED, s[3:0], 1'b0);
                    n++;
                end
                if (n > 0)
                    expected_events[expected_events.size() - 1].last = 1'b1;
            end
            default: ;   // unused mode: ignored by the block
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // ---------------- driver ----------------
    timer_cmd_t cur_cmd;
    int in_gap = 0;
    logic in_busy;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            in_busy = in_valid && in_stall;
            if (in_valid && !in_stall)
            begin
                predict_timer_events(cur_cmd);
                accepted++;
                // about two items in five get no gap, so bursts happen too
                in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            if (!in_busy)
            begin
                if (in_gap == 0 && pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    mode <= cur_cmd.mode;
                    delay <= cur_cmd.delay;
                    period <= cur_cmd.period;
                    timer_id <= cur_cmd.timer_id;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
            end
        end
    end

    // ---------------- long receiver hold-off, counted here ----------------
    int cycle_count = 0;
    logic hold_off = 1'b0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        hold_off <= (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN);
    end

    // ---------------- monitor and checker ----------------
    int out_gap = 0;
    timer_event_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("unexpected transaction, kind", 32'(kind), 32'd0);
                else
                begin
                    want = expected_events.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", 32'(kind), 32'(want.kind));
                    if (slot !== want.slot)
                        report_mismatch("slot", 32'(slot), 32'(want.slot));
                    if (active_count !== want.active_count)
                        report_mismatch("active_count", 32'(active_count),
                                        32'(want.active_count));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
                out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            else if (out_gap > 0)
                out_gap--;
            out_stall <= hold_off || (out_gap > 0);
        end
    end

    // ---------------- stimulus ----------------
    function automatic timer_cmd_t make_cmd(logic [1:0] m, logic [31:0] d, logic [31:0] p,
                                            logic [3:0] id);
        timer_cmd_t c;
        c.mode = m;
        c.delay = d;
        c.period = p;
        c.timer_id = id;
        return c;
    endfunction

    function automatic timer_cmd_t random_cmd();
        int r;
        logic [31:0] d;
        logic [31:0] p;
        r = $urandom_range(0, 99);
        d = ($urandom_range(0, 39) == 0) ? $urandom() : $urandom_range(0, 6);
        case ($urandom_range(0, 5))
            0, 1, 2: p = 0;
            3, 4:    p = $urandom_range(1, 5);
            default: p = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(6, 20);
        endcase
        if (r < 55)
            return make_cmd(tss_pkg::MODE_TICK, $urandom(), $urandom(), 4'($urandom()));
        else if (r < 83)
            return make_cmd(tss_pkg::MODE_CREATE, d, p, 4'($urandom()));
        else if (r < 97)
            return make_cmd(tss_pkg::MODE_STOP, $urandom(), $urandom(),
                            4'($urandom_range(0, 15)));
        else
            return make_cmd(MODE_UNUSED, $urandom(), $urandom(), 4'($urandom()));
    endfunction

    initial
    begin
        now_us = '0;
        free_depth = 0;
        next_fresh = 0;
        seq_num = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sched_q[i] = 1'b0;
            dead_q[i] = 1'b0;
            used_q[i] = 1'b0;
        end

        // fill the pool with equal deadlines, overflow it, then one tick hits the cap
        for (int i = 0; i < SLOTS; i++)
            queue_cmd(make_cmd(tss_pkg::MODE_CREATE, 32'd1, 32'd0, 4'd0));
        queue_cmd(make_cmd(tss_pkg::MODE_CREATE, 32'd5, 32'd5, 4'd0));
        queue_cmd(make_cmd(tss_pkg::MODE_TICK, '0, '0, '0));
        // zero-delay periodic fires twice; stop twice, bad id, unused mode
        queue_cmd(make_cmd(tss_pkg::MODE_CREATE, 32'd0, 32'd1, 4'd0));
        queue_cmd(make_cmd(tss_pkg::MODE_CREATE, 32'd0, 32'd0, 4'd0));
        queue_cmd(make_cmd(tss_pkg::MODE_TICK, '0, '0, '0));
        queue_cmd(make_cmd(tss_pkg::MODE_STOP, '0, '0, 4'd15));
        queue_cmd(make_cmd(tss_pkg::MODE_STOP, '0, '0, 4'd15));
        queue_cmd(make_cmd(tss_pkg::MODE_STOP, '0, '0, 4'd3));
        queue_cmd(make_cmd(MODE_UNUSED, '1, '1, '1));
        queue_cmd(make_cmd(tss_pkg::MODE_TICK, '1, '1, '1));   // only the stopped slot is due; it is freed silently
        queue_cmd(make_cmd(tss_pkg::MODE_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0));
        queue_cmd(make_cmd(tss_pkg::MODE_TICK, '0, '0, '0));
        for (int i = 0; i < 202; i++)
            queue_cmd(random_cmd());
        n_items = pending_cmds.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted == n_items && expected_events.size() == 0);
        repeat (60) @(posedge clk);   // let a quiet tick scan finish
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
